### src/rtpsb_pkg.sv
// Package for the rectangular-to-polar spectrum bin converter.
// Holds fixed-point coefficients, widths, register indexes and the queue entry type.
// Used by every module under src except the checker.
package rtpsb_pkg;

    localparam int IN_W    = 32;
    localparam int MAG_W   = 32;
    localparam int PHASE_W = 16;

    // Fast-atan2 coefficients in Q.16.
    localparam logic signed [18:0] COEF_A   = 19'sd12865;
    localparam logic signed [18:0] COEF_B   = 19'sd64337;
    localparam logic signed [18:0] PHASE_C0 = 19'sd51472;
    localparam logic signed [18:0] PHASE_C1 = 19'sd154416;
    localparam logic signed [17:0] ONE_Q16  = 18'sd65536;

    // Ratio r lies in [-1, 1] in Q.16, so 18 signed bits hold it.
    localparam int RATIO_W = 18;
    // Number of divider steps, one quotient bit per step.
    localparam int DIV_STEPS = 17;

    localparam logic [0:0] REG_SIZE_LOG2  = 1'b0;
    localparam logic [0:0] REG_ZERO_PHASE = 1'b1;

    // Entry passed from the front end to the back end through the queue.
    typedef struct packed {
        logic [63:0] sq;        // re^2 + im^2
        logic [32:0] num_mag;   // |numerator| of the ratio
        logic [32:0] den;       // denominator of the ratio, never negative
        logic        num_neg;   // sign of the numerator
        logic        den_zero;  // both parts zero
        logic        re_neg;    // selects the 3pi/4 branch
        logic        im_neg;    // negate the phase
        logic        zero_ph;   // phase forced to zero
        logic [4:0]  shift;     // magnitude shift captured with the item
    } rtpsb_entry_t;

endpackage

### src/rtpsb_front.sv
// Front end: accepts bins, squares the parts and forms the ratio terms.
// Depends on rtpsb_pkg. Two register stages, advances when the queue has room.
module rtpsb_front #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [31:0]                in_re,
    input  logic [31:0]                in_im,
    input  logic [4:0]                 cfg_shift,
    input  logic                       cfg_zero_ph,
    output logic                       out_valid,
    input  logic                       out_ready,
    output rtpsb_pkg::rtpsb_entry_t    out_entry
);

    logic                    v1_reg, v2_reg;
    logic signed [32:0]      re1_reg, a1_reg;
    logic                    im_neg1_reg, zp1_reg;
    logic [4:0]              sh1_reg;
    rtpsb_pkg::rtpsb_entry_t e2_reg, e2_next;
    logic                    adv2, adv1;
    logic signed [31:0]      re_s, im_s;
    logic signed [32:0]      num, den;
    logic [63:0]             re_sq, a_sq;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    // Sign-extend the low SAMPLE_WIDTH bits.
    assign re_s = 32'(signed'(in_re[SAMPLE_WIDTH-1:0]));
    assign im_s = 32'(signed'(in_im[SAMPLE_WIDTH-1:0]));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= in_valid;
            if (adv2) v2_reg <= v1_reg;
        end
        if (adv1) begin
            re1_reg     <= 33'(re_s);
            a1_reg      <= im_s[31] ? -33'(im_s) : 33'(im_s);
            im_neg1_reg <= im_s[31];
            zp1_reg     <= cfg_zero_ph;
            sh1_reg     <= cfg_shift;
        end
        if (adv2) e2_reg <= e2_next;
    end

    always_comb begin
        re_sq = 64'(re1_reg) * 64'(re1_reg);
        a_sq  = 64'(a1_reg) * 64'(a1_reg);
        if (!re1_reg[32]) begin
            num = re1_reg - a1_reg;
            den = re1_reg + a1_reg;
        end else begin
            num = re1_reg + a1_reg;
            den = a1_reg - re1_reg;
        end
        e2_next.sq       = re_sq + a_sq;
        e2_next.num_neg  = num[32];
        e2_next.num_mag  = num[32] ? 33'(-num) : 33'(num);
        e2_next.den      = den;
        e2_next.den_zero = (den == 33'sd0);
        e2_next.re_neg   = re1_reg[32];
        e2_next.im_neg   = im_neg1_reg;
        e2_next.zero_ph  = zp1_reg;
        e2_next.shift    = sh1_reg;
    end

    assign out_valid = v2_reg;
    assign out_entry = e2_reg;

endmodule

### src/rtpsb_queue.sv
// Short queue that decouples the front end from the back end.
// Depends on rtpsb_pkg for the entry type. Two entries, registered flags.
module rtpsb_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    wr_valid,
    output logic                    wr_ready,
    input  rtpsb_pkg::rtpsb_entry_t wr_entry,
    output logic                    rd_valid,
    input  logic                    rd_ready,
    output rtpsb_pkg::rtpsb_entry_t rd_entry
);

    rtpsb_pkg::rtpsb_entry_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;
    assign rd_entry = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
        if (wr) mem_reg[wp_reg] <= wr_entry;
    end

endmodule

### src/rtpsb_back.sv
// Back end: pipelined square root, ratio divider and cubic atan polynomial.
// Depends on rtpsb_pkg. One bin per cycle, fixed latency, stalls as a whole.
module rtpsb_back (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rtpsb_pkg::rtpsb_entry_t in_entry,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [31:0]             out_mag,
    output logic [15:0]             out_phase
);

    localparam int SQ_STAGES = 32;          // one result bit per stage
    localparam int DS        = rtpsb_pkg::DIV_STEPS;
    localparam int NST       = SQ_STAGES;   // divider fits inside sqrt stages
    localparam int TOT       = NST + 5;

    typedef struct packed {
        logic        num_neg;
        logic        den_zero;
        logic        re_neg;
        logic        im_neg;
        logic        zero_ph;
        logic [4:0]  shift;
    } side_t;

    logic        adv;
    logic [TOT-1:0] v_reg;

    // Square root pipeline state.
    logic [63:0] srem_reg [NST+1];
    logic [31:0] sres_reg [NST+1];
    // Divider pipeline state: remainder, denominator and quotient.
    logic [33:0] drem_reg [NST+1];
    logic [32:0] dden_reg [NST+1];
    logic [16:0] dq_reg   [NST+1];
    side_t       sd_reg   [NST+1];

    // Polynomial stages.
    logic signed [17:0] r_p1_reg, r_p2_reg;
    logic signed [35:0] r2_p1_reg;
    logic signed [18:0] t_p2_reg;
    logic signed [36:0] tr_p3_reg;
    logic [31:0]        mag_p1_reg, mag_p2_reg, mag_p3_reg, mag_o_reg;
    side_t              sd_p1_reg, sd_p2_reg, sd_p3_reg;
    logic [15:0]        ph_o_reg;

    assign adv      = !v_reg[TOT-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) v_reg <= '0;
        else if (adv) v_reg <= {v_reg[TOT-2:0], in_valid};
    end

    // Stage 0 loads the entry.
    always_ff @(posedge aclk) begin
        if (adv) begin
            srem_reg[0] <= in_entry.sq;
            sres_reg[0] <= '0;
            drem_reg[0] <= 34'(in_entry.num_mag);
            dden_reg[0] <= in_entry.den;
            dq_reg[0]   <= '0;
            sd_reg[0]   <= '{in_entry.num_neg, in_entry.den_zero, in_entry.re_neg,
                             in_entry.im_neg, in_entry.zero_ph, in_entry.shift};
        end
    end

    // Each stage settles one bit of the root and, in the first stages,
    // one bit of the quotient num*65536/den (num <= den, so 17 bits).
    // The divider shifts its remainder left by one after each step.
    for (genvar g = 0; g < NST; g++) begin : g_st
        logic [31:0] cand;
        logic [63:0] csq;
        logic [63:0] sub;
        always_comb begin
            cand = sres_reg[g] | (32'd1 << (31 - g));
            csq  = 64'(cand) * 64'(cand);
            sub  = 64'd0;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                sd_reg[g+1]   <= sd_reg[g];
                dden_reg[g+1] <= dden_reg[g];
                srem_reg[g+1] <= srem_reg[g];
                sres_reg[g+1] <= (csq <= srem_reg[g] + sub) ? cand : sres_reg[g];
            end
        end
        if (g < DS) begin : g_div
            logic [33:0] dsh;
            logic [33:0] trial;
            always_comb begin
                dsh   = 34'(dden_reg[g]);
                trial = drem_reg[g] - dsh;
            end
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (drem_reg[g] >= dsh) begin
                        drem_reg[g+1] <= trial << 1;
                        dq_reg[g+1]   <= dq_reg[g] | (17'd1 << (DS - 1 - g));
                    end else begin
                        drem_reg[g+1] <= drem_reg[g] << 1;
                        dq_reg[g+1]   <= dq_reg[g];
                    end
                end
            end
        end else begin : g_pass
            always_ff @(posedge aclk) begin
                if (adv) begin
                    drem_reg[g+1] <= drem_reg[g];
                    dq_reg[g+1]   <= dq_reg[g];
                end
            end
        end
    end

    logic signed [17:0] r_fin;
    logic signed [36:0] ar2;
    logic signed [18:0] c_sel;
    logic signed [18:0] p_val;
    logic signed [15:0] q_val;

    always_comb begin
        if (sd_reg[NST].den_zero) r_fin = -rtpsb_pkg::ONE_Q16;
        else if (sd_reg[NST].num_neg) r_fin = -18'(signed'({1'b0, dq_reg[NST]}));
        else r_fin = 18'(signed'({1'b0, dq_reg[NST]}));
        ar2   = 37'(rtpsb_pkg::COEF_A) * 37'(r2_p1_reg >>> 16);
        c_sel = sd_p3_reg.re_neg ? rtpsb_pkg::PHASE_C1 : rtpsb_pkg::PHASE_C0;
        p_val = c_sel + 19'(tr_p3_reg >>> 16);
        q_val = 16'((p_val + 19'sd4) >>> 3);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_p1_reg   <= r_fin;
            r2_p1_reg  <= r_fin * r_fin;
            mag_p1_reg <= sres_reg[NST] >> sd_reg[NST].shift;
            sd_p1_reg  <= sd_reg[NST];

            r_p2_reg   <= r_p1_reg;
            t_p2_reg   <= 19'(ar2 >>> 16) - rtpsb_pkg::COEF_B;
            mag_p2_reg <= mag_p1_reg;
            sd_p2_reg  <= sd_p1_reg;

            tr_p3_reg  <= 37'(t_p2_reg) * 37'(r_p2_reg);
            mag_p3_reg <= mag_p2_reg;
            sd_p3_reg  <= sd_p2_reg;

            mag_o_reg  <= mag_p3_reg;
            if (sd_p3_reg.zero_ph) ph_o_reg <= '0;
            else if (sd_p3_reg.im_neg) ph_o_reg <= -q_val;
            else ph_o_reg <= q_val;
        end
    end

    assign out_valid = v_reg[TOT-1];
    assign out_mag   = mag_o_reg;
    assign out_phase = ph_o_reg;

endmodule

### src/rect_to_polar_spectrum_bin.sv
// Top level of the rectangular-to-polar spectrum bin converter.
// Depends on rtpsb_pkg, rtpsb_front, rtpsb_queue and rtpsb_back.
//
// Usage:
// The s_ channel takes one FFT bin per transfer: s_tdata carries real_part
// in bits 31:0 and imag_part in bits 63:32, two's complement. The m_ channel
// returns one result per bin: m_tdata carries the magnitude in bits 31:0 and
// the Q3.13 phase in bits 47:32.
// The APB port holds two registers: size_log2 at address 0 and
// zero_phase_mode at address 4. They are sampled with each bin as it enters.
// Throughput is one bin per cycle while the receiver accepts. Without stalls a
// result passes through two front-end stages, one queue stage, 33 stages
// of square root and divider, three polynomial stages and the output register.
// Reset clears all valid flags and loads size_log2 = 10, zero_phase_mode = 0.
// When the receiver stalls, the back end holds, the two-entry queue fills,
// and then the front end and s_tready drop; no transfer is lost.
module rect_to_polar_spectrum_bin #(
    parameter int SAMPLE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // real_part[31:0], imag_part[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,     // magnitude[31:0], phase_angle[47:32]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0] size_log2_reg;
    logic       zero_phase_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Registers are written at the access phase of an APB write.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_log2_reg  <= 5'd10;
            zero_phase_reg <= 1'b0;
        end else if (wr_en) begin
            unique case (paddr[2])
                rtpsb_pkg::REG_SIZE_LOG2:  size_log2_reg  <= pwdata[4:0];
                rtpsb_pkg::REG_ZERO_PHASE: zero_phase_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            rtpsb_pkg::REG_SIZE_LOG2:  prdata = {27'd0, size_log2_reg};
            rtpsb_pkg::REG_ZERO_PHASE: prdata = {31'd0, zero_phase_reg};
            default:                   prdata = '0;
        endcase
    end

    logic                    f_valid, f_ready, b_valid, b_ready;
    rtpsb_pkg::rtpsb_entry_t f_entry, b_entry;
    logic [31:0]             mag;
    logic [15:0]             phase;

    rtpsb_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_re(s_tdata[31:0]), .in_im(s_tdata[63:32]),
        .cfg_shift(size_log2_reg), .cfg_zero_ph(zero_phase_reg),
        .out_valid(f_valid), .out_ready(f_ready), .out_entry(f_entry)
    );

    rtpsb_queue u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_entry(f_entry),
        .rd_valid(b_valid), .rd_ready(b_ready), .rd_entry(b_entry)
    );

    rtpsb_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(b_valid), .in_ready(b_ready), .in_entry(b_entry),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_mag(mag), .out_phase(phase)
    );

    assign m_tdata = {phase, mag};

endmodule

### src/rtpsb_checker.sv
// Port-level checker for the rectangular-to-polar converter, bound to the top.
// Depends only on the top level's ports.
module rtpsb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        pready
);

    // A stalled result keeps its data.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Phase stays within plus or minus 25736.
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[47:32]) <= 16'sd25736 &&
                      $signed(m_tdata[47:32]) >= -16'sd25736))
        else $error("phase out of range");

    // No result appears right after reset.
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result after reset");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("pready low");

endmodule

bind rect_to_polar_spectrum_bin rtpsb_checker u_rtpsb_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .pready(pready)
);
